>>> design/yrg_pkg.sv
// ----------------------------------------------------------------------------
// yrg_pkg
// Shared widths, register indexes, reset values and structs for the
// YUV to RGB pixel group converter.
// ----------------------------------------------------------------------------
package yrg_pkg;

    // field widths
    localparam int LUMA_W     = 8;
    localparam int CHROMA_W   = 8;
    localparam int RGB_W      = 8;
    localparam int NUM_LUMA   = 4;
    localparam int IDX_W      = 2;
    localparam int GAIN_W     = 23;
    localparam int COEF_W     = 24;
    localparam int PPC_W      = 3;
    localparam int CENT_W     = 9;
    localparam int PROD_W     = 32;
    localparam int TERM_W     = 34;
    localparam int YY_W       = 31;
    localparam int SUM_W      = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // pixel constants
    localparam logic [LUMA_W-1:0]   LUMA_OFFSET = 8'd16;
    localparam logic [CENT_W-1:0]   CHROMA_MID  = 9'd128;
    localparam logic [RGB_W-1:0]    RGB_MAX     = 8'd255;

    // register reset values
    localparam logic                     RST_OFFSET_MODE = 1'b0;
    localparam logic [GAIN_W-1:0]        RST_GAIN        = 23'd1220542;
    localparam logic signed [COEF_W-1:0] RST_V_TO_RED    = 24'sd1673527;
    localparam logic signed [COEF_W-1:0] RST_V_TO_GREEN  = -24'sd852492;
    localparam logic signed [COEF_W-1:0] RST_U_TO_GREEN  = -24'sd409993;
    localparam logic signed [COEF_W-1:0] RST_U_TO_BLUE   = 24'sd2116026;
    localparam logic                     RST_SWAP        = 1'b0;
    localparam logic [PPC_W-1:0]         RST_PPC         = 3'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_OFFSET_MODE  = 3'd0,
        REG_LUMA_GAIN         = 3'd1,
        REG_V_TO_RED          = 3'd2,
        REG_V_TO_GREEN        = 3'd3,
        REG_U_TO_GREEN        = 3'd4,
        REG_U_TO_BLUE         = 3'd5,
        REG_SWAP_CHROMA       = 3'd6,
        REG_PIXELS_PER_CHROMA = 3'd7
    } cfg_reg_t;

    // configuration bundle
    typedef struct packed {
        logic                     offset_mode;
        logic [GAIN_W-1:0]        gain;
        logic signed [COEF_W-1:0] v_to_red;
        logic signed [COEF_W-1:0] v_to_green;
        logic signed [COEF_W-1:0] u_to_green;
        logic signed [COEF_W-1:0] u_to_blue;
        logic                     swap;
        logic [PPC_W-1:0]         ppc;
    } cfg_t;

    // one classified group: chroma terms, luma samples, index of the last pixel
    typedef struct packed {
        logic signed [TERM_W-1:0]          r_term;
        logic signed [TERM_W-1:0]          g_term;
        logic signed [TERM_W-1:0]          b_term;
        logic [NUM_LUMA-1:0][LUMA_W-1:0]   luma;
        logic [IDX_W-1:0]                  last_idx;
    } grp_t;

    // queue head towards the back end
    typedef struct packed {
        logic valid;
        grp_t data;
    } q_head_t;

endpackage

>>> design/yrg_front.sv
// ----------------------------------------------------------------------------
// yrg_front
// Accepts a word, centres the chroma, forms the chroma products and pushes
// the rounded chroma terms with the luma samples into the queue.
// ----------------------------------------------------------------------------
module yrg_front
    import yrg_pkg::*;
#(
    parameter int COEF_BITS = 20,
    parameter int MAX_GROUP = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHROMA_W-1:0]  s_chroma_first,
    input  logic [CHROMA_W-1:0]  s_chroma_second,
    input  logic [LUMA_W-1:0]    s_luma0,
    input  logic [LUMA_W-1:0]    s_luma1,
    input  logic [LUMA_W-1:0]    s_luma2,
    input  logic [LUMA_W-1:0]    s_luma3,
    input  logic                 q_full,
    output logic                 push,
    output grp_t                 push_data
);

    localparam logic signed [TERM_W-1:0] HALF = TERM_W'(1) << (COEF_BITS - 1);
    localparam logic [PPC_W-1:0]         MAX_N = PPC_W'(MAX_GROUP);

    logic signed [CENT_W-1:0] cent_a, cent_b, cent_u, cent_v;
    logic [IDX_W-1:0]         last_idx;
    logic                     load;

    logic                            f_valid_reg, f_valid_next;
    logic signed [PROD_W-1:0]        f_vr_reg, f_vg_reg, f_ug_reg, f_ub_reg;
    logic [NUM_LUMA-1:0][LUMA_W-1:0] f_luma_reg;
    logic [IDX_W-1:0]                f_last_reg;

    // centred chroma, swapped on request
    assign cent_a = {1'b0, s_chroma_first} - CHROMA_MID;
    assign cent_b = {1'b0, s_chroma_second} - CHROMA_MID;
    assign cent_u = cfg.swap ? cent_b : cent_a;
    assign cent_v = cfg.swap ? cent_a : cent_b;

    // group size clamp, held as index of the last pixel
    always_comb begin
        if (cfg.ppc == '0) begin
            last_idx = '0;
        end else if (cfg.ppc > MAX_N) begin
            last_idx = IDX_W'(MAX_N - 3'd1);
        end else begin
            last_idx = IDX_W'(cfg.ppc - 3'd1);
        end
    end

    // single stage: takes a word when the stage is empty or empties into the queue
    assign s_ready = !f_valid_reg || !q_full;
    assign load    = s_valid && s_ready;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_ready) begin
            f_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    // chroma products
    always_ff @(posedge aclk) begin
        if (load) begin
            f_vr_reg   <= PROD_W'($signed(cfg.v_to_red))   * PROD_W'(cent_v);
            f_vg_reg   <= PROD_W'($signed(cfg.v_to_green)) * PROD_W'(cent_v);
            f_ug_reg   <= PROD_W'($signed(cfg.u_to_green)) * PROD_W'(cent_u);
            f_ub_reg   <= PROD_W'($signed(cfg.u_to_blue))  * PROD_W'(cent_u);
            f_luma_reg <= {s_luma3, s_luma2, s_luma1, s_luma0};
            f_last_reg <= last_idx;
        end
    end

    // rounded chroma terms into the queue
    assign push = f_valid_reg && !q_full;

    always_comb begin
        push_data.r_term   = HALF + TERM_W'(f_vr_reg);
        push_data.g_term   = HALF + TERM_W'(f_vg_reg) + TERM_W'(f_ug_reg);
        push_data.b_term   = HALF + TERM_W'(f_ub_reg);
        push_data.luma     = f_luma_reg;
        push_data.last_idx = f_last_reg;
    end

endmodule

>>> design/yrg_queue.sv
// ----------------------------------------------------------------------------
// yrg_queue
// Two-entry queue of classified groups between the front and back ends.
// ----------------------------------------------------------------------------
module yrg_queue
    import yrg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  grp_t    push_data,
    output logic    full,
    input  logic    pop,
    output q_head_t head
);

    grp_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/yrg_back.sv
// ----------------------------------------------------------------------------
// yrg_back
// Walks the queue head's luma one per cycle unless stalled: luma gain product,
// then add to each chroma term, shift and saturate into the output register.
// ----------------------------------------------------------------------------
module yrg_back
    import yrg_pkg::*;
#(
    parameter int COEF_BITS = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              offset_mode,
    input  logic [GAIN_W-1:0] gain,
    input  q_head_t           head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RGB_W-1:0]  m_red,
    output logic [RGB_W-1:0]  m_green,
    output logic [RGB_W-1:0]  m_blue,
    output logic              m_last_of_group
);

    // floor shift and clamp to 0..255
    function automatic logic [RGB_W-1:0] sat8(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] q;
        q = SUM_W'($unsigned(s)) >> COEF_BITS;
        if (s[SUM_W-1]) begin
            return '0;
        end else if (|q[SUM_W-1:RGB_W]) begin
            return RGB_MAX;
        end else begin
            return q[RGB_W-1:0];
        end
    endfunction

    logic [IDX_W-1:0]  k_reg, k_next;
    logic [LUMA_W-1:0] y_raw, y_adj;
    logic              last_pix;
    logic              b_en, a_ld, issue;

    logic                     a_valid_reg, a_valid_next;
    logic [YY_W-1:0]          a_yy_reg;
    logic signed [TERM_W-1:0] a_r_reg, a_g_reg, a_b_reg;
    logic                     a_last_reg;

    logic signed [SUM_W-1:0]  yy_s, sum_r, sum_g, sum_b;
    logic                     m_valid_reg, m_valid_next;
    logic [RGB_W-1:0]         m_red_reg, m_green_reg, m_blue_reg;
    logic                     m_last_reg;

    // stage enables, stalling from the output back
    assign b_en  = !m_valid_reg || m_ready;
    assign a_ld  = !a_valid_reg || b_en;
    assign issue = head.valid && a_ld;

    // luma sequencer over the group
    assign last_pix = (k_reg == head.data.last_idx);
    assign pop      = issue && last_pix;

    always_comb begin
        k_next = k_reg;
        if (issue) begin
            k_next = last_pix ? '0 : k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

    // luma offset with floor at zero, skipped when offset_mode is set
    assign y_raw = head.data.luma[k_reg];
    always_comb begin
        if (offset_mode) begin
            y_adj = y_raw;
        end else if (y_raw > LUMA_OFFSET) begin
            y_adj = y_raw - LUMA_OFFSET;
        end else begin
            y_adj = '0;
        end
    end

    // stage a: luma gain product
    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ld) begin
            a_valid_next = issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            a_yy_reg   <= YY_W'(y_adj) * YY_W'(gain);
            a_r_reg    <= head.data.r_term;
            a_g_reg    <= head.data.g_term;
            a_b_reg    <= head.data.b_term;
            a_last_reg <= last_pix;
        end
    end

    // stage b: sums and saturation into the output register
    assign yy_s  = SUM_W'($signed({1'b0, a_yy_reg}));
    assign sum_r = yy_s + SUM_W'(a_r_reg);
    assign sum_g = yy_s + SUM_W'(a_g_reg);
    assign sum_b = yy_s + SUM_W'(a_b_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (b_en) begin
            m_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_en && a_valid_reg) begin
            m_red_reg   <= sat8(sum_r);
            m_green_reg <= sat8(sum_g);
            m_blue_reg  <= sat8(sum_b);
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red           = m_red_reg;
    assign m_green         = m_green_reg;
    assign m_blue          = m_blue_reg;
    assign m_last_of_group = m_last_reg;

endmodule

>>> design/yuv_to_rgb_pixel_group_core.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_group_core
// Fixed-point YUV to RGB conversion of one chroma pair and up to four luma
// samples sharing it, one RGB pixel out per luma.
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      chroma_first, chroma_second,
//                                             luma0..luma3
//  m_       out        m_valid / m_ready      red, green, blue, last_of_group
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel leaves per cycle while m_ready holds; a word occupies the back end
// for n pixels (n the clamped group size, 1 to MAX_GROUP), as the luma walk sets
// the rate. Words pass the front stage, queue, stage a and output register.
// Synchronous active-low reset empties the pipeline and queue and loads the
// register reset values. A stalled output holds the back end; the front end
// and two-entry queue keep accepting words until full.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_group_core
    import yrg_pkg::*;
#(
    parameter int COEF_BITS = 20,
    parameter int MAX_GROUP = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CHROMA_W-1:0]   s_chroma_first,
    input  logic [CHROMA_W-1:0]   s_chroma_second,
    input  logic [LUMA_W-1:0]     s_luma0,
    input  logic [LUMA_W-1:0]     s_luma1,
    input  logic [LUMA_W-1:0]     s_luma2,
    input  logic [LUMA_W-1:0]     s_luma3,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RGB_W-1:0]      m_red,
    output logic [RGB_W-1:0]      m_green,
    output logic [RGB_W-1:0]      m_blue,
    output logic                  m_last_of_group
);

    cfg_t    cfg_reg, cfg_next;
    logic    push, pop, q_full;
    grp_t    push_data;
    q_head_t head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LUMA_OFFSET_MODE:  cfg_next.offset_mode = cfg_data[0];
                REG_LUMA_GAIN:         cfg_next.gain        = cfg_data[GAIN_W-1:0];
                REG_V_TO_RED:          cfg_next.v_to_red    = cfg_data[COEF_W-1:0];
                REG_V_TO_GREEN:        cfg_next.v_to_green  = cfg_data[COEF_W-1:0];
                REG_U_TO_GREEN:        cfg_next.u_to_green  = cfg_data[COEF_W-1:0];
                REG_U_TO_BLUE:         cfg_next.u_to_blue   = cfg_data[COEF_W-1:0];
                REG_SWAP_CHROMA:       cfg_next.swap        = cfg_data[0];
                REG_PIXELS_PER_CHROMA: cfg_next.ppc         = cfg_data[PPC_W-1:0];
                default:               cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_mode <= RST_OFFSET_MODE;
            cfg_reg.gain        <= RST_GAIN;
            cfg_reg.v_to_red    <= RST_V_TO_RED;
            cfg_reg.v_to_green  <= RST_V_TO_GREEN;
            cfg_reg.u_to_green  <= RST_U_TO_GREEN;
            cfg_reg.u_to_blue   <= RST_U_TO_BLUE;
            cfg_reg.swap        <= RST_SWAP;
            cfg_reg.ppc         <= RST_PPC;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept and classify
    yrg_front #(
        .COEF_BITS (COEF_BITS),
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_chroma_first  (s_chroma_first),
        .s_chroma_second (s_chroma_second),
        .s_luma0         (s_luma0),
        .s_luma1         (s_luma1),
        .s_luma2         (s_luma2),
        .s_luma3         (s_luma3),
        .q_full          (q_full),
        .push            (push),
        .push_data       (push_data)
    );

    // group queue
    yrg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    // back end: per-pixel conversion
    yrg_back #(
        .COEF_BITS (COEF_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .offset_mode     (cfg_reg.offset_mode),
        .gain            (cfg_reg.gain),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_last_of_group (m_last_of_group)
    );

endmodule

>>> design/yrg_checker.sv
// ----------------------------------------------------------------------------
// yrg_checker
// Port-level checks on the pixel group converter, bound to the top level.
// ----------------------------------------------------------------------------
module yrg_checker
    import yrg_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [RGB_W-1:0] m_red,
    input logic [RGB_W-1:0] m_green,
    input logic [RGB_W-1:0] m_blue,
    input logic             m_last_of_group
);

    // no pixel straight out of reset
    a_reset_no_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("pixel valid right after reset");

    // front end empty and ready after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // a stalled pixel stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("pixel withdrawn while stalled");

    // a stalled pixel keeps its value
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_red, m_green, m_blue, m_last_of_group}))
        else $error("pixel changed while stalled");

endmodule

bind yuv_to_rgb_pixel_group_core yrg_checker u_yrg_checker (.*);
